>>> rtl/bmp_rle_pixel_decoder_defines.svh
// ---------------------------------------------------------------------------
// BMP RLE decoder assertion macros
// Shared assertion helpers for the decoder RTL.
// ---------------------------------------------------------------------------
`ifndef BMP_RLE_PIXEL_DECODER_DEFINES_SVH
`define BMP_RLE_PIXEL_DECODER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BRD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bmp rle decoder: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define BRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bmp rle decoder: next-cycle check failed");

`endif

>>> rtl/brd_pkg.sv
// ---------------------------------------------------------------------------
// BMP RLE decoder package
// Widths, register indexes, status codes and shared structs.
// ---------------------------------------------------------------------------
package brd_pkg;

  localparam int BYTE_W    = 8;
  localparam int COORD_W   = 12;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 12;

  localparam int MAX_DIM_DEFAULT = 4096;

  localparam logic [CFG_IDX_W-1:0] REG_NIBBLE_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_RUN   = 3'd0,
    ST_EOL   = 3'd1,
    ST_DONE  = 3'd2,
    ST_DELTA = 3'd3,
    ST_OVER  = 3'd4
  } status_t;

  typedef struct packed {
    logic               nibble_mode;
    logic [COORD_W-1:0] image_width;
    logic [COORD_W-1:0] image_height;
  } cfg_t;

  typedef struct packed {
    status_t            status;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] column;
    logic [BYTE_W-1:0]  run_length;
    logic [BYTE_W-1:0]  first_value;
    logic [BYTE_W-1:0]  second_value;
  } run_result_t;

endpackage

>>> rtl/brd_stream_if.sv
// ---------------------------------------------------------------------------
// BMP RLE decoder byte channel
// Valid/ready channel carrying one compressed stream byte per request.
// ---------------------------------------------------------------------------
interface brd_stream_if;
  import brd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

>>> rtl/brd_run_if.sv
// ---------------------------------------------------------------------------
// BMP RLE decoder run channel
// Valid/ready channel carrying one run command or status per request.
// ---------------------------------------------------------------------------
interface brd_run_if;
  import brd_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COORD_W-1:0]  row;
  logic [COORD_W-1:0]  column;
  logic [BYTE_W-1:0]   run_length;
  logic [BYTE_W-1:0]   first_value;
  logic [BYTE_W-1:0]   second_value;

  modport source (
    output valid, output status, output row, output column,
    output run_length, output first_value, output second_value,
    input ready
  );
  modport sink (
    input valid, input status, input row, input column,
    input run_length, input first_value, input second_value,
    output ready
  );
endinterface

>>> rtl/brd_core.sv
// ---------------------------------------------------------------------------
// BMP RLE decoder core
// Byte-pair parser state and the run command produced by each byte.
// ---------------------------------------------------------------------------
`include "bmp_rle_pixel_decoder_defines.svh"

module brd_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [brd_pkg::BYTE_W-1:0]   stream_byte,
  input  brd_pkg::cfg_t                cfg,
  output logic                         res_valid,
  output brd_pkg::run_result_t         res
);
  import brd_pkg::*;

  typedef enum logic [1:0] {
    PH_COUNT   = 2'd0,
    PH_SECOND  = 2'd1,
    PH_LITERAL = 2'd2,
    PH_PAD     = 2'd3
  } phase_t;

  phase_t             phase, phase_next;
  logic [BYTE_W-1:0]  held_count, held_count_next;
  logic [BYTE_W-1:0]  literal_left, literal_left_next;
  logic               pad_needed, pad_needed_next;
  logic [COORD_W-1:0] column_pos, column_pos_next;
  logic [COORD_W-1:0] file_row, file_row_next;
  logic               stopped, stopped_next;

  logic [BYTE_W-1:0]  add_n;
  logic [BYTE_W-1:0]  lit_n;
  logic [COORD_W:0]   col_sum;
  logic               col_over;
  logic               last_row;
  logic [3:0]         hi_nib;
  logic [3:0]         lo_nib;
  logic [BYTE_W-1:0]  lit_plus1;
  logic               res_stops;

  assign hi_nib    = stream_byte[7:4];
  assign lo_nib    = stream_byte[3:0];
  assign lit_plus1 = stream_byte + 8'd1;

  // A 4-bit literal byte carries two pixels unless only one is left.
  always_comb begin
    if (!cfg.nibble_mode) begin
      lit_n = 8'd1;
    end else if (literal_left >= 8'd2) begin
      lit_n = 8'd2;
    end else begin
      lit_n = literal_left;
    end
  end

  always_comb begin
    if (phase == PH_SECOND) begin
      add_n = (held_count != '0) ? held_count : stream_byte;
    end else begin
      add_n = lit_n;
    end
  end

  assign col_sum  = {1'b0, column_pos} + {{(COORD_W + 1 - BYTE_W){1'b0}}, add_n};
  assign col_over = col_sum > {1'b0, cfg.image_width};
  assign last_row = ({1'b0, file_row} + 13'd1) >= {1'b0, cfg.image_height};

  always_comb begin
    phase_next        = phase;
    held_count_next   = held_count;
    literal_left_next = literal_left;
    pad_needed_next   = pad_needed;
    column_pos_next   = column_pos;
    file_row_next     = file_row;
    stopped_next      = stopped;
    res_valid         = 1'b0;
    res               = '0;
    res.status        = ST_RUN;
    res.row           = cfg.image_height - 12'd1 - file_row;
    res.column        = column_pos;

    if (!stopped) begin
      unique case (phase)
        PH_COUNT: begin
          held_count_next = stream_byte;
          phase_next      = PH_SECOND;
        end
        PH_SECOND: begin
          phase_next = PH_COUNT;
          priority if (held_count != '0) begin
            res_valid = 1'b1;
            if (col_over) begin
              stopped_next   = 1'b1;
              res.status     = ST_OVER;
              res.run_length = held_count;
            end else begin
              res.run_length = held_count;
              if (cfg.nibble_mode) begin
                res.first_value  = {4'd0, hi_nib};
                res.second_value = {4'd0, lo_nib};
              end else begin
                res.first_value  = stream_byte;
                res.second_value = stream_byte;
              end
              column_pos_next = col_sum[COORD_W-1:0];
            end
          end else if (stream_byte == 8'd0) begin
            res_valid = 1'b1;
            if (last_row) begin
              stopped_next = 1'b1;
              res.status   = ST_DONE;
            end else begin
              res.status      = ST_EOL;
              file_row_next   = file_row + 12'd1;
              column_pos_next = '0;
            end
          end else if (stream_byte == 8'd1) begin
            res_valid    = 1'b1;
            stopped_next = 1'b1;
            res.status   = ST_DONE;
          end else if (stream_byte == 8'd2) begin
            res_valid    = 1'b1;
            stopped_next = 1'b1;
            res.status   = ST_DELTA;
          end else if (col_over) begin
            res_valid      = 1'b1;
            stopped_next   = 1'b1;
            res.status     = ST_OVER;
            res.run_length = stream_byte;
          end else begin
            // Literal groups are padded to a 16-bit boundary in the stream.
            literal_left_next = stream_byte;
            pad_needed_next   = cfg.nibble_mode ? lit_plus1[1] : stream_byte[0];
            phase_next        = PH_LITERAL;
          end
        end
        PH_LITERAL: begin
          res_valid      = 1'b1;
          res.run_length = lit_n;
          if (cfg.nibble_mode) begin
            res.first_value  = {4'd0, hi_nib};
            res.second_value = {4'd0, lo_nib};
          end else begin
            res.first_value  = stream_byte;
            res.second_value = stream_byte;
          end
          column_pos_next   = col_sum[COORD_W-1:0];
          literal_left_next = literal_left - lit_n;
          if (literal_left == lit_n) begin
            phase_next = pad_needed ? PH_PAD : PH_COUNT;
          end
        end
        PH_PAD: begin
          phase_next = PH_COUNT;
        end
        default: begin
          phase_next = PH_COUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_COUNT;
      held_count   <= '0;
      literal_left <= '0;
      pad_needed   <= 1'b0;
      column_pos   <= '0;
      file_row     <= '0;
      stopped      <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      held_count   <= held_count_next;
      literal_left <= literal_left_next;
      pad_needed   <= pad_needed_next;
      column_pos   <= column_pos_next;
      file_row     <= file_row_next;
      stopped      <= stopped_next;
    end
  end

  // Image complete, delta and overflow all end decoding.
  assign res_stops = res_valid && (res.status == ST_DONE || res.status == ST_DELTA ||
                                   res.status == ST_OVER);

  `BRD_ASSERT_NEXT(a_stop_sticky, clk, rst, stopped, stopped)
  `BRD_ASSERT_NEXT(a_term_stops, clk, rst, step && res_stops, stopped)
  `BRD_ASSERT_NOW(a_stopped_idle_phase, clk, rst, stopped, phase == PH_COUNT)
  `BRD_ASSERT_NOW(a_literal_nonzero, clk, rst, phase == PH_LITERAL, literal_left != '0)

endmodule

>>> rtl/bmp_rle_pixel_decoder.sv
// A byte's result is offered on the run channel from the result register.
// Throughput: one byte per cycle unless run stalls; a byte with no result takes a slot.
// The input register and the result register let a new byte enter while a result waits.
// Reset (synchronous, active high) clears the parser, the valid flags and the
// registers: 8-bit mode, width 1, height 1.
// ---------------------------------------------------------------------------
// BMP RLE pixel decoder
// Parses an RLE8/RLE4 BMP pixel stream into run commands and row status.
// ---------------------------------------------------------------------------
module bmp_rle_pixel_decoder #(
  parameter int MAX_DIM = brd_pkg::MAX_DIM_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [brd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [brd_pkg::CFG_W-1:0]      cfg_wdata,
  brd_stream_if.sink                     stream,
  brd_run_if.source                      run
);
  import brd_pkg::*;

  localparam int DIM_LIMIT = MAX_DIM - 1;

  cfg_t               cfg;
  logic [COORD_W-1:0] dim_value;

  logic               in_valid;
  logic [BYTE_W-1:0]  in_byte;
  logic               advance;

  logic               res_valid;
  run_result_t        res;
  logic               out_valid;
  run_result_t        out_q;

  // Dimension writes at or above the limit saturate to the largest size.
  always_comb begin
    if ({20'd0, cfg_wdata} >= 32'(MAX_DIM)) begin
      dim_value = COORD_W'(DIM_LIMIT);
    end else begin
      dim_value = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.nibble_mode  <= 1'b0;
      cfg.image_width  <= 12'd1;
      cfg.image_height <= 12'd1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_NIBBLE_MODE:  cfg.nibble_mode  <= cfg_wdata[0];
        REG_IMAGE_WIDTH:  cfg.image_width  <= dim_value;
        REG_IMAGE_HEIGHT: cfg.image_height <= dim_value;
        default: ;
      endcase
    end
  end

  assign advance      = in_valid && (!out_valid || run.ready);
  assign stream.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (stream.ready) begin
      in_valid <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      in_byte <= stream.stream_byte;
    end
  end

  brd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .stream_byte (in_byte),
    .cfg         (cfg),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end else if (run.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign run.valid        = out_valid;
  assign run.status       = out_q.status;
  assign run.row          = out_q.row;
  assign run.column       = out_q.column;
  assign run.run_length   = out_q.run_length;
  assign run.first_value  = out_q.first_value;
  assign run.second_value = out_q.second_value;

endmodule

>>> tb/sv/brd_stream_codes_pkg.sv
// ---------------------------------------------------------------------------
// BMP RLE stream codes
// Escape bytes of the compressed pixel stream, shared by the stimulus side and
// the run checker.
// ---------------------------------------------------------------------------
package brd_stream_codes_pkg;

  localparam logic [7:0] ESC_MARK      = 8'h00;
  localparam logic [7:0] ESC_END_ROW   = 8'h00;
  localparam logic [7:0] ESC_END_IMAGE = 8'h01;
  localparam logic [7:0] ESC_DELTA     = 8'h02;

  // Counts below this after an escape are control codes, not literal groups.
  localparam int LITERAL_MIN = 3;

endpackage

>>> tb/sv/brd_run_checker.sv
// ---------------------------------------------------------------------------
// BMP RLE decoder run checker
// Watches the configuration port and both channels, decodes every accepted
// stream byte into the run it should cause and compares each accepted run
// command field by field against the oldest one due.
// ---------------------------------------------------------------------------
module brd_run_checker
  import brd_pkg::*;
  import brd_stream_codes_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  brd_stream_if                stream,
  brd_run_if                   run,
  output int unsigned          fail_count,
  output int unsigned          outstanding
);

  localparam int PRINT_LIMIT = 40;

  typedef enum logic [1:0] {
    EXPECT_COUNT,
    EXPECT_VALUE,
    EXPECT_LITERAL,
    EXPECT_PAD
  } parse_phase_e;

  parse_phase_e       phase;
  logic [BYTE_W-1:0]  held_count;
  logic [BYTE_W-1:0]  literal_left;
  logic               pad_needed;
  logic [COORD_W-1:0] column_pos;
  logic [COORD_W-1:0] file_row;
  logic               stopped;

  logic               nibble_mode;
  logic [COORD_W-1:0] image_width;
  logic [COORD_W-1:0] image_height;

  run_result_t        due_runs[$];
  int unsigned        runs_checked;

  task automatic flag_mismatch(input string what, input logic [COORD_W-1:0] got,
                               input logic [COORD_W-1:0] want);
    fail_count++;
    if (fail_count <= PRINT_LIMIT)
      $display("run %0d: %s is %0d, should be %0d", runs_checked, what, got, want);
  endtask

  // Rows arrive bottom-up, so the storage row counts down from the top.
  function automatic run_result_t make_run(input status_t st, input logic [BYTE_W-1:0] len,
                                           input logic [BYTE_W-1:0] v0,
                                           input logic [BYTE_W-1:0] v1);
    run_result_t r;
    r.status       = st;
    r.row          = image_height - 12'd1 - file_row;
    r.column       = column_pos;
    r.run_length   = len;
    r.first_value  = v0;
    r.second_value = v1;
    return r;
  endfunction

  function automatic bit fits_in_row(input logic [BYTE_W-1:0] n);
    return ({1'b0, column_pos} + 13'(n)) <= {1'b0, image_width};
  endfunction

  task automatic decode_byte(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] step;
    logic [8:0]        group_bytes;
    if (stopped) return;
    case (phase)
      EXPECT_COUNT: begin
        held_count = b;
        phase      = EXPECT_VALUE;
      end
      EXPECT_VALUE: begin
        phase = EXPECT_COUNT;
        if (held_count != 8'd0) begin
          if (!fits_in_row(held_count)) begin
            due_runs.push_back(make_run(ST_OVER, held_count, 8'd0, 8'd0));
            stopped = 1'b1;
          end else begin
            if (nibble_mode)
              due_runs.push_back(make_run(ST_RUN, held_count, {4'd0, b[7:4]}, {4'd0, b[3:0]}));
            else
              due_runs.push_back(make_run(ST_RUN, held_count, b, b));
            column_pos = column_pos + 12'(held_count);
          end
        end else if (b == ESC_END_ROW) begin
          if ({1'b0, file_row} + 13'd1 >= {1'b0, image_height}) begin
            due_runs.push_back(make_run(ST_DONE, 8'd0, 8'd0, 8'd0));
            stopped = 1'b1;
          end else begin
            due_runs.push_back(make_run(ST_EOL, 8'd0, 8'd0, 8'd0));
            file_row   = file_row + 12'd1;
            column_pos = '0;
          end
        end else if (b == ESC_END_IMAGE) begin
          due_runs.push_back(make_run(ST_DONE, 8'd0, 8'd0, 8'd0));
          stopped = 1'b1;
        end else if (b == ESC_DELTA) begin
          due_runs.push_back(make_run(ST_DELTA, 8'd0, 8'd0, 8'd0));
          stopped = 1'b1;
        end else if (!fits_in_row(b)) begin
          due_runs.push_back(make_run(ST_OVER, b, 8'd0, 8'd0));
          stopped = 1'b1;
        end else begin
          literal_left = b;
          // The group is padded to an even number of data bytes.
          group_bytes  = {1'b0, b} + 9'd1;
          pad_needed   = nibble_mode ? group_bytes[1] : b[0];
          phase        = EXPECT_LITERAL;
        end
      end
      EXPECT_LITERAL: begin
        if (nibble_mode) begin
          step = (literal_left >= 8'd2) ? 8'd2 : literal_left;
          due_runs.push_back(make_run(ST_RUN, step, {4'd0, b[7:4]}, {4'd0, b[3:0]}));
        end else begin
          step = 8'd1;
          due_runs.push_back(make_run(ST_RUN, step, b, b));
        end
        column_pos   = column_pos + 12'(step);
        literal_left = literal_left - step;
        if (literal_left == 8'd0)
          phase = pad_needed ? EXPECT_PAD : EXPECT_COUNT;
      end
      default: begin
        phase = EXPECT_COUNT;
      end
    endcase
  endtask

  task automatic check_run();
    run_result_t want;
    runs_checked++;
    if (due_runs.size() == 0) begin
      flag_mismatch("run with none due, status", 12'(run.status), '0);
      return;
    end
    want = due_runs.pop_front();
    if (run.status !== want.status)
      flag_mismatch("status", 12'(run.status), 12'(want.status));
    if (run.row !== want.row)
      flag_mismatch("row", run.row, want.row);
    if (run.column !== want.column)
      flag_mismatch("column", run.column, want.column);
    if (run.run_length !== want.run_length)
      flag_mismatch("run_length", 12'(run.run_length), 12'(want.run_length));
    if (run.first_value !== want.first_value)
      flag_mismatch("first_value", 12'(run.first_value), 12'(want.first_value));
    if (run.second_value !== want.second_value)
      flag_mismatch("second_value", 12'(run.second_value), 12'(want.second_value));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      phase        = EXPECT_COUNT;
      held_count   = '0;
      literal_left = '0;
      pad_needed   = 1'b0;
      column_pos   = '0;
      file_row     = '0;
      stopped      = 1'b0;
      nibble_mode  = 1'b0;
      image_width  = 12'd1;
      image_height = 12'd1;
      due_runs.delete();
      fail_count   = 0;
      runs_checked = 0;
    end else begin
      if (run.valid && run.ready) check_run();
      // Dimensions are 12 bits wide, so the clamp at the default size never applies.
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_NIBBLE_MODE:  nibble_mode  = cfg_wdata[0];
          REG_IMAGE_WIDTH:  image_width  = cfg_wdata;
          REG_IMAGE_HEIGHT: image_height = cfg_wdata;
          default: ;
        endcase
      end
      if (stream.valid && stream.ready) decode_byte(stream.stream_byte);
    end
    outstanding = due_runs.size();
  end

endmodule

>>> tb/sv/tb_bmp_rle_pixel_decoder.sv
// ---------------------------------------------------------------------------
// BMP RLE pixel decoder testbench
// Feeds well-formed RLE8/RLE4 byte streams through several image settings,
// with random gaps on both channels and one long stall of the run channel,
// then ends the image with a randomly chosen terminating case and checks that
// the bytes after it are dropped. The run checker does all comparisons.
// ---------------------------------------------------------------------------
module tb_bmp_rle_pixel_decoder;
  import brd_pkg::*;
  import brd_stream_codes_pkg::*;

  localparam int RESET_CYCLES  = 12;
  localparam int QUIET_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int RANDOM_BYTES  = 1750;
  localparam int RANDOM_PHASES = 8;
  localparam int HOLD_CYCLES   = 200;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum int {
    END_BY_ESCAPE,
    END_BY_DELTA,
    END_BY_RUN_OVERFLOW,
    END_BY_LITERAL_OVERFLOW,
    END_BY_LAST_ROW
  } ending_e;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]   cfg_wdata;

  int unsigned        fail_total;
  int unsigned        runs_outstanding;
  int unsigned        quiet_cycles = 0;

  // What the stream generator knows about the decoder, to keep streams legal.
  int unsigned        sent_count = 0;
  bit                 send_calm  = 1'b0;
  bit                 cur_mode;
  int                 cur_w;
  int                 cur_h;
  int                 line_fill;
  int                 rows_done;

  brd_stream_if stream_ch ();
  brd_run_if    run_ch ();

  bmp_rle_pixel_decoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .stream    (stream_ch),
    .run       (run_ch)
  );

  brd_run_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .stream      (stream_ch),
    .run         (run_ch),
    .fail_count  (fail_total),
    .outstanding (runs_outstanding)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if ((stream_ch.valid && stream_ch.ready) || (run_ch.valid && run_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] value);
    int gap;
    if (sent_count % 64 == 0) send_calm = ($urandom_range(0, 3) == 0);
    gap = send_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      stream_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    stream_ch.valid       <= 1'b1;
    stream_ch.stream_byte <= value;
    do @(posedge clk); while (!stream_ch.ready);
    sent_count++;
    @(negedge clk);
  endtask

  // Waits until every run due has come back and the pipeline has drained.
  task automatic settle();
    stream_ch.valid <= 1'b0;
    while (runs_outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_config(input bit mode, input int w, input int h);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_NIBBLE_MODE;
    cfg_wdata <= {11'($urandom), mode};
    @(negedge clk);
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_wdata <= 12'(w);
    @(negedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_wdata <= 12'(h);
    @(negedge clk);
    cfg_index <= REG_SPARE;
    cfg_wdata <= 12'($urandom);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_mode = mode;
    cur_w    = w;
    cur_h    = h;
  endtask

  task automatic send_repeat(input int n, input logic [BYTE_W-1:0] value);
    send_byte(8'(n));
    send_byte(value);
    line_fill += n;
  endtask

  task automatic send_literal(input int n);
    int data_bytes;
    data_bytes = cur_mode ? (n + 1) / 2 : n;
    send_byte(ESC_MARK);
    send_byte(8'(n));
    repeat (data_bytes) send_byte(8'($urandom));
    if (data_bytes % 2 != 0) send_byte(8'($urandom));
    line_fill += n;
  endtask

  task automatic send_end_of_row();
    send_byte(ESC_MARK);
    send_byte(ESC_END_ROW);
    rows_done++;
    line_fill = 0;
  endtask

  // Mostly short runs, now and then any length up to the limit, or the limit itself.
  function automatic int pick_count(input int lo, input int hi);
    case ($urandom_range(0, 7))
      0:       return $urandom_range(lo, hi);
      1:       return hi;
      default: return $urandom_range(lo, (hi < lo + 15) ? hi : lo + 15);
    endcase
  endfunction

  task automatic fill_phase(input int unsigned stop_at, input bit allow_eol);
    int room;
    int pick;
    while (sent_count < stop_at) begin
      room = cur_w - line_fill;
      if (room > 255) room = 255;
      pick = $urandom_range(0, 99);
      if (room >= 1 && pick < 45)
        send_repeat(pick_count(1, room), 8'($urandom));
      else if (room >= LITERAL_MIN && pick < 80)
        send_literal(pick_count(LITERAL_MIN, room));
      else if (allow_eol && rows_done + 1 < cur_h)
        send_end_of_row();
      else if (room >= 1)
        send_repeat(pick_count(1, room), 8'($urandom));
      else
        break;
    end
  endtask

  initial begin : result_taker
    int unsigned taken;
    int unsigned hold_at;
    int          stall;
    bit          calm;
    taken   = 0;
    calm    = 1'b0;
    hold_at = $urandom_range(150, 400);
    run_ch.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (taken % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      stall = calm ? 0 : $urandom_range(0, 11);
      // One long hold-off so the decoder fills up and stops taking requests.
      if (taken == hold_at) stall = HOLD_CYCLES;
      if (stall > 0) begin
        run_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      run_ch.ready <= 1'b1;
      do @(posedge clk); while (!run_ch.valid);
      taken++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int      w;
    int      h;
    int      n;
    int      w_final;
    int      h_final;
    bit      mode;
    ending_e ending;

    rst                   = 1'b1;
    cfg_wr_en             = 1'b0;
    cfg_index             = REG_NIBBLE_MODE;
    cfg_wdata             = '0;
    stream_ch.valid       = 1'b0;
    stream_ch.stream_byte = '0;
    cur_mode              = 1'b0;
    cur_w                 = 1;
    cur_h                 = 1;
    line_fill             = 0;
    rows_done             = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: a one-pixel run fills the single one-pixel row.
    send_repeat(1, 8'h7E);
    settle();

    set_config(1'b0, 4095, 4095);
    send_repeat(255, 8'h00);
    send_repeat(1, 8'hFF);
    send_literal(3);
    send_end_of_row();
    settle();

    // Odd 4-bit literals: three pixels need no pad, five pixels do.
    set_config(1'b1, 4095, 4095);
    send_repeat(5, 8'hAB);
    send_literal(3);
    send_literal(5);
    send_end_of_row();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      case (p)
        0: w = 4095;
        1: w = 1;
        default: begin
          case ($urandom_range(0, 3))
            0:       w = 1;
            1:       w = 4095;
            2:       w = $urandom_range(2, 32);
            default: w = $urandom_range(1, 4095);
          endcase
        end
      endcase
      h    = (p == 0) ? 4095 : $urandom_range(rows_done + 2, 4095);
      mode = (p < 2) ? 1'(p) : 1'($urandom_range(0, 1));
      set_config(mode, w, h);
      fill_phase(sent_count + RANDOM_BYTES / RANDOM_PHASES, 1'b1);
    end

    // Start a fresh row, then shrink the image; a height below the current
    // row makes the storage row wrap around.
    settle();
    set_config(cur_mode, cur_w, 4095);
    send_end_of_row();
    settle();
    ending  = ending_e'($urandom_range(0, 4));
    w_final = $urandom_range(1, 64);
    h_final = (ending == END_BY_LAST_ROW) ? $urandom_range(1, rows_done + 1)
                                          : $urandom_range(1, 4095);
    set_config(1'($urandom_range(0, 1)), w_final, h_final);
    fill_phase(sent_count + $urandom_range(0, 24), 1'b0);

    case (ending)
      END_BY_ESCAPE: begin
        send_byte(ESC_MARK);
        send_byte(ESC_END_IMAGE);
      end
      END_BY_DELTA: begin
        send_byte(ESC_MARK);
        send_byte(ESC_DELTA);
      end
      END_BY_RUN_OVERFLOW: begin
        send_repeat($urandom_range(w_final - line_fill + 1, 255), 8'($urandom));
      end
      END_BY_LITERAL_OVERFLOW: begin
        n = w_final - line_fill + 1;
        if (n < LITERAL_MIN) n = LITERAL_MIN;
        send_byte(ESC_MARK);
        send_byte(8'($urandom_range(n, 255)));
      end
      default: begin
        send_end_of_row();
      end
    endcase

    // The decoder has stopped; everything after this must be dropped.
    repeat (16) send_byte(8'($urandom));
    settle();

    if (fail_total == 0 && runs_outstanding == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
